FILE: rtl/core/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

    localparam int LETTER_W            = 5;
    localparam int SQUARE_SIDE_DEFAULT = 5;
    localparam int STORED_CELLS        = 25;
    localparam int KEY_BITS            = STORED_CELLS * LETTER_W;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 50;
    localparam int CELLS_LOW_W = 50;
    localparam int CELLS_MID_W = 50;
    localparam int CELLS_HIGH_W = 25;

    localparam logic [CFG_INDEX_W-1:0] REG_CELLS_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CELLS_MID  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CELLS_HIGH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DECRYPT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FILLER     = 3'd4;

    localparam logic [LETTER_W-1:0] FILLER_RESET = 5'd23;

    // Result buffer: up to two pairs per item
    localparam int SLOT_COUNT = 4;
    localparam int SLOT_CNT_W = 3;
    localparam logic [SLOT_CNT_W-1:0] ONE_PAIR_COUNT  = 3'd2;
    localparam logic [SLOT_CNT_W-1:0] TWO_PAIR_COUNT  = 3'd4;

    typedef logic [LETTER_W-1:0] letter_t;

    typedef struct packed {
        letter_t first;
        letter_t second;
    } pair_t;

    typedef struct packed {
        logic  valid;
        logic  two;
        logic  last;
        pair_t pair0;
        pair_t pair1;
    } pair_bundle_t;

    typedef struct packed {
        letter_t first;
        letter_t second;
        logic    error;
    } pair_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/pfc_pairer.sv
`default_nettype none

module pfc_pairer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire pfc_pkg::letter_t      letter_in,
    input  wire logic                  final_letter,
    input  wire pfc_pkg::letter_t      filler,
    input  wire logic                  take,
    output pfc_pkg::pair_bundle_t      bundle
);

    pfc_pkg::letter_t      prev_letter_reg, prev_letter_next;
    logic                  prev_valid_reg, prev_valid_next;
    pfc_pkg::letter_t      pend_letter_reg, pend_letter_next;
    logic                  pend_valid_reg, pend_valid_next;
    pfc_pkg::pair_bundle_t bundle_reg, bundle_next;

    logic          accept;
    logic          insert;
    logic          has_pair;
    logic          two_pairs;
    pfc_pkg::pair_t pair0;
    pfc_pkg::pair_t pair1;

    assign in_ready = !bundle_reg.valid || take;
    assign accept   = in_valid && in_ready;
    assign insert   = prev_valid_reg && (letter_in == prev_letter_reg) && (letter_in != filler);
    assign bundle   = bundle_reg;

    always_comb
    begin
        prev_letter_next = prev_letter_reg;
        prev_valid_next  = prev_valid_reg;
        pend_letter_next = pend_letter_reg;
        pend_valid_next  = pend_valid_reg;
        has_pair         = 1'b0;
        two_pairs        = 1'b0;
        pair0            = '{first: pend_letter_reg, second: letter_in};
        pair1            = '{first: letter_in, second: filler};

        if (accept)
        begin
            prev_letter_next = letter_in;
            prev_valid_next  = 1'b1;
            if (insert)
            begin
                has_pair = 1'b1;
                if (pend_valid_reg)
                begin
                    // half pair closes on the filler, letter starts a new one
                    pair0 = '{first: pend_letter_reg, second: filler};
                    if (final_letter)
                    begin
                        two_pairs = 1'b1;
                    end
                    else
                    begin
                        pend_letter_next = letter_in;
                        pend_valid_next  = 1'b1;
                    end
                end
                else
                begin
                    pair0           = '{first: filler, second: letter_in};
                    pend_valid_next = 1'b0;
                end
            end
            else if (pend_valid_reg)
            begin
                has_pair        = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (final_letter)
            begin
                // pad a lone letter at message end
                has_pair = 1'b1;
                pair0    = '{first: letter_in, second: filler};
            end
            else
            begin
                pend_letter_next = letter_in;
                pend_valid_next  = 1'b1;
            end

            if (final_letter)
            begin
                prev_letter_next = '0;
                prev_valid_next  = 1'b0;
                pend_letter_next = '0;
                pend_valid_next  = 1'b0;
            end
        end
    end

    always_comb
    begin
        bundle_next = bundle_reg;
        if (accept && has_pair)
        begin
            bundle_next.valid = 1'b1;
            bundle_next.two   = two_pairs;
            bundle_next.last  = final_letter;
            bundle_next.pair0 = pair0;
            bundle_next.pair1 = pair1;
        end
        else if (take)
        begin
            bundle_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_letter_reg <= '0;
            prev_valid_reg  <= 1'b0;
            pend_letter_reg <= '0;
            pend_valid_reg  <= 1'b0;
            bundle_reg      <= '0;
        end
        else
        begin
            prev_letter_reg <= prev_letter_next;
            prev_valid_reg  <= prev_valid_next;
            pend_letter_reg <= pend_letter_next;
            pend_valid_reg  <= pend_valid_next;
            bundle_reg      <= bundle_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pfc_cipher.sv
`default_nettype none

module pfc_cipher #(
    parameter int SQUARE_SIDE = pfc_pkg::SQUARE_SIDE_DEFAULT
) (
    input  wire logic [SQUARE_SIDE*SQUARE_SIDE*pfc_pkg::LETTER_W-1:0] cells,
    input  wire logic                                                decrypt,
    input  wire pfc_pkg::pair_t                                      pair,
    output pfc_pkg::pair_result_t                                    result
);

    localparam int CELL_COUNT = SQUARE_SIDE * SQUARE_SIDE;
    localparam int CELL_BITS  = CELL_COUNT * pfc_pkg::LETTER_W;

    typedef logic [SQUARE_SIDE-1:0] hot_t;

    logic [CELL_COUNT-1:0] match_a, match_b;
    logic [CELL_COUNT-1:0] first_a, first_b;
    hot_t row_a, col_a, row_b, col_b;
    hot_t out_row_a, out_col_a, out_row_b, out_col_b;
    logic found_a, found_b, same_cell;

    // Rotate a one-hot row or column position by one place, wrapping.
    function automatic hot_t step_hot(input hot_t v, input logic back);
        hot_t r;
        if (back)
        begin
            r = {v[0], v[SQUARE_SIDE-1:1]};
        end
        else
        begin
            r = {v[SQUARE_SIDE-2:0], v[SQUARE_SIDE-1]};
        end
        return r;
    endfunction

    // AND-OR select of the cell at one-hot row and column.
    function automatic pfc_pkg::letter_t read_cell(input logic [CELL_BITS-1:0] cv,
                                                   input hot_t rh, input hot_t ch);
        pfc_pkg::letter_t v;
        v = '0;
        for (int r = 0; r < SQUARE_SIDE; r++)
        begin
            for (int c = 0; c < SQUARE_SIDE; c++)
            begin
                if (rh[r] && ch[c])
                begin
                    v = v | cv[(r*SQUARE_SIDE + c)*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W];
                end
            end
        end
        return v;
    endfunction

    always_comb
    begin
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            match_a[i] = (i < pfc_pkg::STORED_CELLS) &&
                         (cells[i*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W] == pair.first);
            match_b[i] = (i < pfc_pkg::STORED_CELLS) &&
                         (cells[i*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W] == pair.second);
        end
    end

    // Keep only the lowest set match: first cell in row-major order.
    assign first_a = match_a & (~match_a + CELL_COUNT'(1));
    assign first_b = match_b & (~match_b + CELL_COUNT'(1));
    assign found_a = |match_a;
    assign found_b = |match_b;
    assign same_cell = (first_a == first_b);

    always_comb
    begin
        row_a = '0;
        col_a = '0;
        row_b = '0;
        col_b = '0;
        for (int r = 0; r < SQUARE_SIDE; r++)
        begin
            for (int c = 0; c < SQUARE_SIDE; c++)
            begin
                row_a[r] = row_a[r] | first_a[r*SQUARE_SIDE + c];
                col_a[c] = col_a[c] | first_a[r*SQUARE_SIDE + c];
                row_b[r] = row_b[r] | first_b[r*SQUARE_SIDE + c];
                col_b[c] = col_b[c] | first_b[r*SQUARE_SIDE + c];
            end
        end
    end

    always_comb
    begin
        if (row_a == row_b)
        begin
            out_row_a = row_a;
            out_row_b = row_b;
            out_col_a = step_hot(col_a, decrypt);
            out_col_b = step_hot(col_b, decrypt);
        end
        else if (col_a == col_b)
        begin
            out_row_a = step_hot(row_a, decrypt);
            out_row_b = step_hot(row_b, decrypt);
            out_col_a = col_a;
            out_col_b = col_b;
        end
        else
        begin
            out_row_a = row_a;
            out_row_b = row_b;
            out_col_a = col_b;
            out_col_b = col_a;
        end
    end

    always_comb
    begin
        if (!found_a || !found_b || same_cell)
        begin
            // pass the pair through unchanged and flag it
            result.first  = pair.first;
            result.second = pair.second;
            result.error  = 1'b1;
        end
        else
        begin
            result.first  = read_cell(cells, out_row_a, out_col_a);
            result.second = read_cell(cells, out_row_b, out_col_b);
            result.error  = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pfc_out_buffer.sv
`default_nettype none

module pfc_out_buffer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pfc_pkg::pair_bundle_t bundle,
    input  wire pfc_pkg::pair_result_t result0,
    input  wire pfc_pkg::pair_result_t result1,
    output logic                       take,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output pfc_pkg::letter_t           letter_out,
    output logic                       message_end,
    output logic                       pair_error
);

    pfc_pkg::letter_t                    letters_reg [pfc_pkg::SLOT_COUNT];
    pfc_pkg::letter_t                    letters_next [pfc_pkg::SLOT_COUNT];
    logic [pfc_pkg::SLOT_COUNT-1:0]      errs_reg, errs_next;
    logic [pfc_pkg::SLOT_CNT_W-1:0]      count_reg, count_next;
    logic                                last_reg, last_next;
    logic                                drain;
    logic                                draining_last;

    assign out_valid     = (count_reg != '0);
    assign drain         = out_valid && out_ready;
    assign draining_last = drain && (count_reg == pfc_pkg::SLOT_CNT_W'(1));
    assign take          = bundle.valid && ((count_reg == '0) || draining_last);

    assign letter_out  = letters_reg[0];
    assign pair_error  = errs_reg[0];
    assign message_end = last_reg && (count_reg == pfc_pkg::SLOT_CNT_W'(1));

    always_comb
    begin
        letters_next = letters_reg;
        errs_next    = errs_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        if (take)
        begin
            letters_next[0] = result0.first;
            letters_next[1] = result0.second;
            letters_next[2] = result1.first;
            letters_next[3] = result1.second;
            errs_next  = {result1.error, result1.error, result0.error, result0.error};
            count_next = bundle.two ? pfc_pkg::TWO_PAIR_COUNT : pfc_pkg::ONE_PAIR_COUNT;
            last_next  = bundle.last;
        end
        else if (drain)
        begin
            // advance the queue by one letter
            for (int i = 0; i < pfc_pkg::SLOT_COUNT - 1; i++)
            begin
                letters_next[i] = letters_reg[i+1];
            end
            errs_next  = {1'b0, errs_reg[pfc_pkg::SLOT_COUNT-1:1]};
            count_next = count_reg - pfc_pkg::SLOT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letters_reg <= letters_next;
        errs_reg    <= errs_next;
        last_reg    <= last_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/playfair_digraph_cipher_top.sv
// Channel  | Handshake           | Payload                                  | Direction
// ---------+---------------------+------------------------------------------+----------
// input    | in_valid, in_ready  | letter_in[4:0], final_letter             | in
// output   | out_valid,out_ready | letter_out[4:0], message_end, pair_error | out
// config   | cfg_valid,cfg_ready | cfg_index[2:0], cfg_data[49:0]           | in
//
// One letter item is taken per cycle while the pair stage can hand on its work.
// An item yields zero, one or two pairs; each pair leaves as two output items,
// one per cycle while out_ready is high, so an item that closes two pairs gives four items.
// An accepted item passes the pair register, then the result register, before it leaves.
// The output side sets the pace: in_ready drops while the pair register is full and the
// result register cannot take it. Reset clears the pairing state and loads register defaults.
// cfg_ready is always high; a write takes effect at the next edge.
`default_nettype none

module playfair_digraph_cipher_top #(
    parameter int SQUARE_SIDE = pfc_pkg::SQUARE_SIDE_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // letter input
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [pfc_pkg::LETTER_W-1:0]        letter_in,
    input  wire logic                                final_letter,
    // ciphered output
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [pfc_pkg::LETTER_W-1:0]             letter_out,
    output logic                                     message_end,
    output logic                                     pair_error,
    // register writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [pfc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CELL_BITS = SQUARE_SIDE * SQUARE_SIDE * pfc_pkg::LETTER_W;

    logic [pfc_pkg::CELLS_LOW_W-1:0]  cells_low_reg;
    logic [pfc_pkg::CELLS_MID_W-1:0]  cells_mid_reg;
    logic [pfc_pkg::CELLS_HIGH_W-1:0] cells_high_reg;
    logic                             decrypt_reg;
    pfc_pkg::letter_t                 filler_reg;

    logic [pfc_pkg::KEY_BITS-1:0] key_bits;
    logic [CELL_BITS-1:0]         cells;
    logic                         cfg_write;

    pfc_pkg::pair_bundle_t bundle;
    pfc_pkg::pair_result_t result0;
    pfc_pkg::pair_result_t result1;
    logic                  take;

    // Register writes are always taken; unknown indexes drop.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_low_reg  <= '0;
            cells_mid_reg  <= '0;
            cells_high_reg <= '0;
            decrypt_reg    <= 1'b0;
            filler_reg     <= pfc_pkg::FILLER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pfc_pkg::REG_CELLS_LOW:  cells_low_reg  <= cfg_data[pfc_pkg::CELLS_LOW_W-1:0];
                pfc_pkg::REG_CELLS_MID:  cells_mid_reg  <= cfg_data[pfc_pkg::CELLS_MID_W-1:0];
                pfc_pkg::REG_CELLS_HIGH: cells_high_reg <= cfg_data[pfc_pkg::CELLS_HIGH_W-1:0];
                pfc_pkg::REG_DECRYPT:    decrypt_reg    <= cfg_data[0];
                pfc_pkg::REG_FILLER:     filler_reg     <= cfg_data[pfc_pkg::LETTER_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Row-major cell vector, cell 0 lowest. Cells past the stored 25 read as zero
    // and never match (the cipher masks them out).
    assign key_bits = {cells_high_reg, cells_mid_reg, cells_low_reg};
    assign cells    = CELL_BITS'(key_bits);

    // Filler insertion, padding and pair forming; holds one item's pairs.
    pfc_pairer u_pairer (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .letter_in    (letter_in),
        .final_letter (final_letter),
        .filler       (filler_reg),
        .take         (take),
        .bundle       (bundle)
    );

    // Both pairs of an item are ciphered in the same cycle.
    pfc_cipher #(
        .SQUARE_SIDE (SQUARE_SIDE)
    ) u_cipher0 (
        .cells   (cells),
        .decrypt (decrypt_reg),
        .pair    (bundle.pair0),
        .result  (result0)
    );

    pfc_cipher #(
        .SQUARE_SIDE (SQUARE_SIDE)
    ) u_cipher1 (
        .cells   (cells),
        .decrypt (decrypt_reg),
        .pair    (bundle.pair1),
        .result  (result1)
    );

    // Result register: up to four letters, drained one item per cycle while out_ready is high.
    pfc_out_buffer u_out_buffer (
        .clk         (clk),
        .rst_n       (rst_n),
        .bundle      (bundle),
        .result0     (result0),
        .result1     (result1),
        .take        (take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .letter_out  (letter_out),
        .message_end (message_end),
        .pair_error  (pair_error)
    );

endmodule

`default_nettype wire

FILE: rtl/core/pfc_checker.sv
`default_nettype none

module pfc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [pfc_pkg::LETTER_W-1:0] letter_out,
    input wire logic                         message_end,
    input wire logic                         pair_error
);

    logic out_fire;
    logic second_reg;      // next output item is the second letter of a pair
    logic first_err_reg;   // error flag seen on the first letter of the pair
    logic end_seen_reg;    // last output item carried message_end

    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg    <= 1'b0;
            first_err_reg <= 1'b0;
            end_seen_reg  <= 1'b0;
        end
        else if (out_fire)
        begin
            second_reg    <= !second_reg;
            first_err_reg <= pair_error;
            end_seen_reg  <= message_end;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(letter_out) &&
                                    $stable(message_end) && $stable(pair_error))
        else $error("output item changed while stalled");

    a_end_on_second: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && message_end |-> second_reg)
        else $error("message end on the first letter of a pair");

    a_error_pairwise: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && second_reg |-> pair_error == first_err_reg)
        else $error("pair error flag differs between the two letters of a pair");

    a_no_empty_message: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && message_end |-> !end_seen_reg)
        else $error("message end on two consecutive output items");

endmodule

bind playfair_digraph_cipher_top pfc_checker u_pfc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .letter_out  (letter_out),
    .message_end (message_end),
    .pair_error  (pair_error)
);

`default_nettype wire
